// ===== sv/stride_value_predictor_top_defines.svh =====
// ---------------------------------------------------------------------------
// Stride value predictor assertion macros
// Shared macros for the concurrent checks on the predictor's ports.
// ---------------------------------------------------------------------------
`ifndef STRIDE_VALUE_PREDICTOR_TOP_DEFINES_SVH
`define STRIDE_VALUE_PREDICTOR_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define SVP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define SVP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/svp_pkg.sv =====
// ---------------------------------------------------------------------------
// Stride value predictor package
// Types, operation codes and constants shared by the predictor's modules.
// ---------------------------------------------------------------------------
package svp_pkg;

    // Default table geometry.
    localparam int ENTRIES_DEF      = 1024;
    localparam int MAX_INFLIGHT_DEF = 256;

    // Fixed field widths.
    localparam int OP_W   = 3;
    localparam int VAL_W  = 64;
    localparam int CONF_W = 5;

    // Saturation point of the confidence counter.
    localparam logic [CONF_W-1:0] CONF_MAX = 5'd31;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PREDICT = 3'd0;
    localparam logic [OP_W-1:0] OP_TRAIN   = 3'd1;
    localparam logic [OP_W-1:0] OP_INC     = 3'd2;
    localparam logic [OP_W-1:0] OP_DEC     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // Input transaction.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] pc;
        logic [VAL_W-1:0] value;
    } t_svp_in;

    // Result transaction.
    typedef struct packed {
        logic [VAL_W-1:0] predicted_value;
        logic             confident;
    } t_svp_out;

    // One table entry without its in-flight count.
    typedef struct packed {
        logic [VAL_W-1:0]  last_seen;
        logic [VAL_W-1:0]  stride_step;
        logic [CONF_W-1:0] confidence;
    } t_svp_entry;

    // Controller states.
    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_ADD
    } t_svp_state;

endpackage

// ===== sv/svp_table.sv =====
// ---------------------------------------------------------------------------
// Stride value predictor table
// Two synchronous memories: value, stride and confidence in one, the
// in-flight counts in the other, so that a clear can sweep the counts alone.
// ---------------------------------------------------------------------------
module svp_table #(
    parameter int ENTRIES = svp_pkg::ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(svp_pkg::MAX_INFLIGHT_DEF + 1)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [IDX_W-1:0]    i_rd_idx,
    input  logic                i_ent_we,
    input  logic                i_cnt_we,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  svp_pkg::t_svp_entry i_ent_wdata,
    input  logic [CNT_W-1:0]    i_cnt_wdata,
    output svp_pkg::t_svp_entry o_ent_rdata,
    output logic [CNT_W-1:0]    o_cnt_rdata
);

    svp_pkg::t_svp_entry r_ent_mem [ENTRIES];
    logic [CNT_W-1:0]    r_cnt_mem [ENTRIES];
    svp_pkg::t_svp_entry r_ent_q;
    logic [CNT_W-1:0]    r_cnt_q;

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_ent_mem[i_wr_idx] <= i_ent_wdata;
        end
        if (i_rd_en) begin
            r_ent_q <= r_ent_mem[i_rd_idx];
        end
    end

    // Count memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cnt_we) begin
            r_cnt_mem[i_wr_idx] <= i_cnt_wdata;
        end
        if (i_rd_en) begin
            r_cnt_q <= r_cnt_mem[i_rd_idx];
        end
    end

    assign o_ent_rdata = r_ent_q;
    assign o_cnt_rdata = r_cnt_q;

endmodule

// ===== sv/stride_value_predictor_top.sv =====
// ---------------------------------------------------------------------------
// Stride value predictor
// A transaction is accepted in IDLE and passes through READ, where the table read
// returns and the stride multiply is registered, and ADD, where the final add is
// loaded into the result register; a new one is taken only back in IDLE. A clear
// walks the count memory and then strobes its result. After reset the block is busy
// while a clearing pass zeroes the whole table.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module stride_value_predictor_top #(
    parameter int ENTRIES      = svp_pkg::ENTRIES_DEF,
    parameter int MAX_INFLIGHT = svp_pkg::MAX_INFLIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  svp_pkg::t_svp_in  i_cmd,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output logic              o_result_valid,
    output svp_pkg::t_svp_out o_result
);

    // ENTRIES is a power of two, so the index is a slice of the address.
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(MAX_INFLIGHT + 1);
    localparam int VAL_W = svp_pkg::VAL_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_INFLIGHT);

    svp_pkg::t_svp_state r_state, n_state;
    logic                r_clear_all, n_clear_all;
    logic [IDX_W-1:0]    r_sweep_idx, n_sweep_idx;
    logic                r_mode;
    logic                r_result_valid, n_result_valid;

    logic [svp_pkg::OP_W-1:0] r_op;
    logic [IDX_W-1:0]         r_idx;
    logic [VAL_W-1:0]         r_value;
    logic [VAL_W-1:0]         r_prod;
    logic [VAL_W-1:0]         r_last;
    logic                     r_conf_hit;
    logic                     r_is_pred;
    svp_pkg::t_svp_out        r_result;

    logic                accept;
    logic                rd_en;
    logic                ent_we;
    logic                cnt_we;
    logic [IDX_W-1:0]    wr_idx;
    svp_pkg::t_svp_entry ent_wdata;
    logic [CNT_W-1:0]    cnt_wdata;
    svp_pkg::t_svp_entry ent_q;
    logic [CNT_W-1:0]    cnt_q;
    logic                result_load;
    svp_pkg::t_svp_out   result_d;

    logic [CNT_W-1:0]        cnt_up;
    logic [CNT_W-1:0]        cnt_dn;
    logic [CNT_W-1:0]        mul_cnt;
    logic [VAL_W+CNT_W-1:0]  prod_full;
    logic [VAL_W-1:0]        delta;
    logic                    match;
    logic [svp_pkg::CONF_W-1:0] conf_new;

    assign accept = start && (r_state == svp_pkg::ST_IDLE);
    assign busy   = (r_state != svp_pkg::ST_IDLE);

    // Table memories.
    svp_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rd_en     (rd_en),
        .i_rd_idx    (i_cmd.pc[IDX_W+1:2]),
        .i_ent_we    (ent_we),
        .i_cnt_we    (cnt_we),
        .i_wr_idx    (wr_idx),
        .i_ent_wdata (ent_wdata),
        .i_cnt_wdata (cnt_wdata),
        .o_ent_rdata (ent_q),
        .o_cnt_rdata (cnt_q)
    );

    // Entry update arithmetic on the data just read.
    always_comb begin
        cnt_up   = (cnt_q < CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
        cnt_dn   = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
        delta    = r_value - ent_q.last_seen;
        match    = r_mode ? (r_value == ent_q.last_seen) : (delta == ent_q.stride_step);
        if (!match) begin
            conf_new = '0;
        end else if (ent_q.confidence < svp_pkg::CONF_MAX) begin
            conf_new = ent_q.confidence + 1'b1;
        end else begin
            conf_new = ent_q.confidence;
        end
        // In last-value mode the stride term drops out.
        mul_cnt   = r_mode ? '0 : cnt_up;
        prod_full = ent_q.stride_step * mul_cnt;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            svp_pkg::ST_SWEEP: begin
                if (r_sweep_idx == LAST_IDX) begin
                    n_state = svp_pkg::ST_IDLE;
                end
            end
            svp_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = (i_cmd.op == svp_pkg::OP_CLEAR) ? svp_pkg::ST_SWEEP
                                                              : svp_pkg::ST_READ;
                end
            end
            svp_pkg::ST_READ: begin
                n_state = svp_pkg::ST_ADD;
            end
            svp_pkg::ST_ADD: begin
                n_state = svp_pkg::ST_IDLE;
            end
            default: begin
                n_state = svp_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: memory access, sweep control and result loading.
    always_comb begin
        rd_en          = 1'b0;
        ent_we         = 1'b0;
        cnt_we         = 1'b0;
        wr_idx         = r_idx;
        ent_wdata      = '0;
        cnt_wdata      = '0;
        result_load    = 1'b0;
        result_d       = '0;
        n_sweep_idx    = r_sweep_idx;
        n_clear_all    = r_clear_all;
        n_result_valid = 1'b0;
        unique case (r_state)
            svp_pkg::ST_SWEEP: begin
                cnt_we      = 1'b1;
                ent_we      = r_clear_all;
                wr_idx      = r_sweep_idx;
                n_sweep_idx = r_sweep_idx + 1'b1;
                // A clear reports its zero result once the sweep is done.
                if (r_sweep_idx == LAST_IDX && !r_clear_all) begin
                    result_load    = 1'b1;
                    n_result_valid = 1'b1;
                end
            end
            svp_pkg::ST_IDLE: begin
                rd_en = start;
                if (start && i_cmd.op == svp_pkg::OP_CLEAR) begin
                    n_clear_all = 1'b0;
                end
            end
            svp_pkg::ST_READ: begin
                ent_wdata.last_seen   = r_value;
                ent_wdata.stride_step = r_mode ? ent_q.stride_step : delta;
                ent_wdata.confidence  = conf_new;
                unique case (r_op)
                    svp_pkg::OP_PREDICT: begin
                        cnt_we    = !r_mode;
                        cnt_wdata = cnt_up;
                    end
                    svp_pkg::OP_TRAIN: begin
                        ent_we = 1'b1;
                    end
                    svp_pkg::OP_INC: begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_up;
                    end
                    svp_pkg::OP_DEC: begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_dn;
                    end
                    default: begin
                        cnt_we = 1'b0;
                    end
                endcase
            end
            svp_pkg::ST_ADD: begin
                result_load    = 1'b1;
                n_result_valid = 1'b1;
                if (r_is_pred) begin
                    result_d.predicted_value = r_last + r_prod;
                    result_d.confident       = r_conf_hit;
                end
            end
            default: begin
                n_result_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= svp_pkg::ST_SWEEP;
            r_clear_all    <= 1'b1;
            r_sweep_idx    <= '0;
            r_mode         <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clear_all    <= n_clear_all;
            r_sweep_idx    <= n_sweep_idx;
            r_result_valid <= n_result_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    // Transaction and datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_cmd.op;
            r_idx   <= i_cmd.pc[IDX_W+1:2];
            r_value <= i_cmd.value;
        end
        if (r_state == svp_pkg::ST_READ) begin
            r_prod     <= prod_full[VAL_W-1:0];
            r_last     <= ent_q.last_seen;
            r_conf_hit <= (ent_q.confidence == svp_pkg::CONF_MAX);
            r_is_pred  <= (r_op == svp_pkg::OP_PREDICT);
        end
        if (result_load) begin
            r_result <= result_d;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

// ===== sv/svp_checker.sv =====
// ---------------------------------------------------------------------------
// Stride value predictor port checker
// Timing and result checks on the predictor's ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "stride_value_predictor_top_defines.svh"

module svp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input svp_pkg::t_svp_in  i_cmd,
    input logic              o_result_valid,
    input svp_pkg::t_svp_out o_result
);

    // An accepted transaction holds the block busy in the next cycle.
    `SVP_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (start && !busy) |=> busy, "no busy after accept")

    // Every transaction but a clear produces its strobe after a fixed latency.
    `SVP_ASSERT(a_result_latency, i_clk, i_rst_n, (start && !busy && i_cmd.op != svp_pkg::OP_CLEAR) |-> ##3 o_result_valid, "result strobe missing")

    // Train and count operations return an all-zero result.
    `SVP_ASSERT(a_nonpredict_zero, i_clk, i_rst_n, (start && !busy && (i_cmd.op == svp_pkg::OP_TRAIN || i_cmd.op == svp_pkg::OP_INC || i_cmd.op == svp_pkg::OP_DEC)) |-> ##3 (o_result.predicted_value == '0 && !o_result.confident), "non-zero result for a non-predict operation")

    // A result is strobed for a single cycle only.
    `SVP_ASSERT(a_single_strobe, i_clk, i_rst_n, o_result_valid |=> !o_result_valid, "result strobe longer than one cycle")

endmodule

bind stride_value_predictor_top svp_checker u_svp_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Stride value predictor testbench
// Drives predict, train, in-flight and clear commands into the predictor in
// both prediction modes. A shadow copy of the table, kept in step with every
// accepted transaction, gives the expected result. Each strobed result is
// compared field by field against the oldest pending expectation.
// ---------------------------------------------------------------------------
module testbench;

    // Table geometry of the instance under test.
    localparam int TABLE_ENTRIES = svp_pkg::ENTRIES_DEF;
    localparam int COUNT_MAX     = svp_pkg::MAX_INFLIGHT_DEF;

    // Field widths taken from the package.
    localparam int OP_W   = svp_pkg::OP_W;
    localparam int VAL_W  = svp_pkg::VAL_W;
    localparam int CONF_W = svp_pkg::CONF_W;

    // Prediction mode register values.
    localparam logic MODE_STRIDE     = 1'b0;
    localparam logic MODE_LAST_VALUE = 1'b1;

    // Operation codes that the block does not define.
    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

    // Cycles allowed after the last result, and the overall cycle budget.
    localparam int QUIET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PRINT_LIMIT  = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    svp_pkg::t_svp_in   i_cmd;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               o_result_valid;
    svp_pkg::t_svp_out  o_result;

    // Shadow copy of the prediction table and the mode register.
    logic [VAL_W-1:0]  shadow_last   [TABLE_ENTRIES];
    logic [VAL_W-1:0]  shadow_stride [TABLE_ENTRIES];
    logic [CONF_W-1:0] shadow_conf   [TABLE_ENTRIES];
    int unsigned       shadow_count  [TABLE_ENTRIES];
    logic              shadow_mode;

    // Results still owed by the block, oldest first.
    svp_pkg::t_svp_out pending_responses[$];

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 0;

    stride_value_predictor_top #(
        .ENTRIES      (TABLE_ENTRIES),
        .MAX_INFLIGHT (COUNT_MAX)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run-away guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic svp_pkg::t_svp_in make_cmd(logic [OP_W-1:0] op,
                                                  logic [VAL_W-1:0] pc,
                                                  logic [VAL_W-1:0] value);
        svp_pkg::t_svp_in cmd;
        cmd.op    = op;
        cmd.pc    = pc;
        cmd.value = value;
        return cmd;
    endfunction

    // Applies one command to the shadow table and returns the result it owes.
    function automatic svp_pkg::t_svp_out shadow_table_step(svp_pkg::t_svp_in cmd);
        svp_pkg::t_svp_out rsp;
        int unsigned       idx;
        logic [VAL_W-1:0]  delta;
        logic              hit;
        rsp = '0;
        idx = int'((cmd.pc >> 2) % 64'(TABLE_ENTRIES));
        case (cmd.op)
            svp_pkg::OP_PREDICT: begin
                if (shadow_mode == MODE_STRIDE) begin
                    if (shadow_count[idx] < COUNT_MAX)
                        shadow_count[idx]++;
                    rsp.predicted_value = shadow_last[idx]
                                        + shadow_stride[idx] * 64'(shadow_count[idx]);
                end else begin
                    rsp.predicted_value = shadow_last[idx];
                end
                rsp.confident = (shadow_conf[idx] == svp_pkg::CONF_MAX);
            end
            svp_pkg::OP_TRAIN: begin
                if (shadow_mode == MODE_STRIDE) begin
                    delta = cmd.value - shadow_last[idx];
                    hit   = (delta == shadow_stride[idx]);
                    shadow_stride[idx] = delta;
                end else begin
                    hit = (cmd.value == shadow_last[idx]);
                end
                if (!hit)
                    shadow_conf[idx] = '0;
                else if (shadow_conf[idx] < svp_pkg::CONF_MAX)
                    shadow_conf[idx]++;
                shadow_last[idx] = cmd.value;
            end
            svp_pkg::OP_INC: begin
                if (shadow_count[idx] < COUNT_MAX)
                    shadow_count[idx]++;
            end
            svp_pkg::OP_DEC: begin
                if (shadow_count[idx] > 0)
                    shadow_count[idx]--;
            end
            svp_pkg::OP_CLEAR: begin
                foreach (shadow_count[i])
                    shadow_count[i] = 0;
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // One line per mismatch, up to PRINT_LIMIT; the count decides the verdict.
    task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
                                   logic [VAL_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Sends one transaction, with random idle cycles ahead of it.
    task automatic send_command(svp_pkg::t_svp_in cmd);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= cmd;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pending_responses.push_back(shadow_table_step(cmd));
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic wait_for_quiet();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // Mode change, made only while the block is idle.
    task automatic set_prediction_mode(logic mode);
        wait_for_quiet();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        shadow_mode = mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Result checker: each strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        svp_pkg::t_svp_out want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("result with no transaction pending",
                                o_result.predicted_value, '0);
            end else begin
                want = pending_responses.pop_front();
                if (o_result.predicted_value !== want.predicted_value)
                    report_mismatch("predicted_value", o_result.predicted_value,
                                    want.predicted_value);
                if (o_result.confident !== want.confident)
                    report_mismatch("confident", 64'(o_result.confident),
                                    64'(want.confident));
            end
        end
    end

    // Field extremes, wrap-around, aliasing, floor at zero, reserved ops, clear.
    task automatic test_stride_corners();
        logic [VAL_W-1:0] ones;
        ones = '1;
        send_command(make_cmd(svp_pkg::OP_PREDICT, '0, '0));
        send_command(make_cmd(svp_pkg::OP_DEC, '0, ones));
        send_command(make_cmd(svp_pkg::OP_DEC, '0, '0));
        send_command(make_cmd(svp_pkg::OP_PREDICT, ones, ones));
        send_command(make_cmd(svp_pkg::OP_TRAIN, ones, ones));
        send_command(make_cmd(svp_pkg::OP_TRAIN, ones, '0));
        send_command(make_cmd(svp_pkg::OP_TRAIN, ones, 64'd1));
        // Same entry reached through an address with the upper bits clear.
        send_command(make_cmd(svp_pkg::OP_PREDICT, 64'h0000_0000_0000_0ffc, '0));
        send_command(make_cmd(svp_pkg::OP_INC, 64'h8000_0000_0000_0ffd, '0));
        send_command(make_cmd(svp_pkg::OP_PREDICT, ones, '0));
        send_command(make_cmd(OP_RESERVED_FIRST, ones, ones));
        send_command(make_cmd(OP_RESERVED_FIRST + 3'd1, ones, ones));
        send_command(make_cmd(OP_RESERVED_LAST, ones, ones));
        send_command(make_cmd(svp_pkg::OP_CLEAR, random_word(), random_word()));
        send_command(make_cmd(svp_pkg::OP_PREDICT, ones, '0));
        send_command(make_cmd(svp_pkg::OP_TRAIN, '0, ones));
        send_command(make_cmd(svp_pkg::OP_PREDICT, '0, '0));
    endtask

    // Last-value mode: repeat hits, misses and an untouched in-flight count.
    task automatic test_last_value_corners();
        logic [VAL_W-1:0] pc;
        logic [VAL_W-1:0] data;
        pc   = random_word();
        data = random_word();
        send_command(make_cmd(svp_pkg::OP_TRAIN, pc, data));
        send_command(make_cmd(svp_pkg::OP_TRAIN, pc, data));
        send_command(make_cmd(svp_pkg::OP_PREDICT, pc, '0));
        send_command(make_cmd(svp_pkg::OP_INC, pc, '0));
        send_command(make_cmd(svp_pkg::OP_PREDICT, pc, '0));
        send_command(make_cmd(svp_pkg::OP_TRAIN, pc, ~data));
        send_command(make_cmd(svp_pkg::OP_PREDICT, pc, '0));
        send_command(make_cmd(svp_pkg::OP_DEC, pc, '0));
    endtask

    // Drives one entry's in-flight count to its ceiling while a steady stride
    // trains its confidence to saturation; then steps the count back down.
    task automatic test_count_and_confidence_saturation();
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] step;
        logic [VAL_W-1:0] pc;
        int               trains;
        base   = random_word();
        step   = random_word();
        trains = 0;
        for (int i = 0; i < 300; i++) begin
            // Vary the address bits that do not select the entry.
            pc = {52'(random_word() >> 12), 10'h155, 2'($urandom_range(3))};
            if (i % 8 == 0) begin
                send_command(make_cmd(svp_pkg::OP_TRAIN, pc, base + step * 64'(trains)));
                trains++;
            end else if (i % 8 == 4) begin
                send_command(make_cmd(svp_pkg::OP_PREDICT, pc, random_word()));
            end else begin
                send_command(make_cmd(svp_pkg::OP_INC, pc, random_word()));
            end
        end
        for (int i = 0; i < 6; i++) begin
            send_command(make_cmd(svp_pkg::OP_DEC, {52'd0, 10'h155, 2'd0}, '0));
            send_command(make_cmd(svp_pkg::OP_PREDICT, {52'd0, 10'h155, 2'd3}, '0));
        end
    endtask

    // Mostly training runs with random base and stride on a small set of
    // addresses, mixed with broken values and random noise.
    task automatic test_random_traffic(int item_goal, int idle_pct);
        logic [VAL_W-1:0] pc_pool [6];
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] step;
        logic [VAL_W-1:0] seq_pc;
        logic [VAL_W-1:0] data;
        logic [OP_W-1:0]  op_code;
        int               sent;
        int               seq_len;
        int               pick;
        int               trains;
        sender_idle_pct = idle_pct;
        foreach (pc_pool[i])
            pc_pool[i] = random_word();
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(99) < 80) begin
                seq_pc = pc_pool[$urandom_range(5)];
                base   = random_word();
                case ($urandom_range(2))
                    0: step = '0;
                    1: step = 64'($urandom_range(16)) - 64'd8;
                    default: step = random_word();
                endcase
                seq_len = $urandom_range(4, 48);
                trains  = 0;
                for (int k = 0; k < seq_len; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 70) begin
                        data = base + step * 64'(trains);
                        if ($urandom_range(19) == 0)
                            data = random_word();
                        send_command(make_cmd(svp_pkg::OP_TRAIN, seq_pc, data));
                        trains++;
                    end else if (pick < 85) begin
                        send_command(make_cmd(svp_pkg::OP_PREDICT, seq_pc, random_word()));
                    end else if (pick < 93) begin
                        send_command(make_cmd(svp_pkg::OP_INC, seq_pc, random_word()));
                    end else begin
                        send_command(make_cmd(svp_pkg::OP_DEC, seq_pc, random_word()));
                    end
                end
                sent += seq_len;
            end else begin
                // Clears walk the whole table, so most of them are swapped out.
                op_code = OP_W'($urandom_range(OP_RESERVED_LAST));
                if (op_code == svp_pkg::OP_CLEAR && $urandom_range(3) != 0)
                    op_code = svp_pkg::OP_INC;
                send_command(make_cmd(op_code, random_word(), random_word()));
                sent++;
            end
        end
        sender_idle_pct = 0;
    endtask

    // Test sequence.
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        foreach (shadow_last[i]) begin
            shadow_last[i]   = '0;
            shadow_stride[i] = '0;
            shadow_conf[i]   = '0;
            shadow_count[i]  = 0;
        end
        shadow_mode = MODE_STRIDE;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_prediction_mode(MODE_STRIDE);
        test_stride_corners();
        set_prediction_mode(MODE_LAST_VALUE);
        test_last_value_corners();
        set_prediction_mode(MODE_STRIDE);
        test_count_and_confidence_saturation();
        set_prediction_mode(MODE_LAST_VALUE);
        test_random_traffic(25, 0);
        set_prediction_mode(MODE_STRIDE);
        test_random_traffic(25, 63);
        set_prediction_mode(MODE_LAST_VALUE);
        test_random_traffic(25, 28);
        set_prediction_mode(MODE_STRIDE);
        test_random_traffic(25, 0);
        wait_for_quiet();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
